### rtl/core/clx_pkg.sv
package clx_pkg;

  localparam int unsigned KwMaxChars = 8;
  localparam int unsigned MaxTokens  = 4;
  localparam int unsigned QueueDepth = 4;

  localparam logic [2:0] KIND_RESERVED = 3'd0;
  localparam logic [2:0] KIND_IDENT    = 3'd1;
  localparam logic [2:0] KIND_NUMBER   = 3'd2;
  localparam logic [2:0] KIND_STRING   = 3'd3;
  localparam logic [2:0] KIND_CHAR     = 3'd4;
  localparam logic [2:0] KIND_END      = 3'd5;
  localparam logic [2:0] KIND_ERROR    = 3'd6;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_OPEN_COM  = 3'd1;
  localparam logic [2:0] ERR_BAD_CHAR  = 3'd2;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd3;
  localparam logic [2:0] ERR_OPEN_LIT  = 3'd4;

  localparam logic [5:0] CODE_NONE     = 6'd63;
  localparam logic [5:0] CODE_ELLIPSIS = 6'd20;
  localparam logic [5:0] CODE_SLASH_EQ = 6'd24;
  localparam logic [5:0] CODE_DOT      = 6'd46;
  localparam logic [5:0] CODE_SLASH    = 6'd52;

  localparam logic [30:0] ValueMax = 31'h7FFF_FFFF;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_WORD, MODE_NUM, MODE_STR, MODE_CHR_FIRST, MODE_CHR_BODY,
    MODE_SLASH, MODE_LINECOM, MODE_BLOCKCOM, MODE_PUNCT, MODE_DOT, MODE_DISCARD
  } lex_mode_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [5:0]  reserved_code;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [30:0] token_value;
    logic [2:0]  error_code;
    logic        last_token;
  } token_t;

  typedef struct packed {
    token_t [MaxTokens-1:0] toks;
    logic   [2:0]           cnt;
  } bundle_t;

  function automatic token_t mk_tok(logic [2:0] kind, logic [5:0] code,
                                    logic [15:0] start, logic [15:0] len,
                                    logic [30:0] val, logic [2:0] err,
                                    logic last);
    token_t t;
    t.token_kind    = kind;
    t.reserved_code = code;
    t.token_start   = start;
    t.token_length  = len;
    t.token_value   = val;
    t.error_code    = err;
    t.last_token    = last;
    return t;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic has_pair(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
           c == "&" || c == "|" || c == "=" || c == "!" || c == "<" ||
           c == ">" || c == ".";
  endfunction

  function automatic logic [5:0] single_code(logic [7:0] c);
    logic [5:0] k;
    case (c)
      "[": k = 6'd18;
      "]": k = 6'd19;
      "|": k = 6'd31;
      "^": k = 6'd32;
      "&": k = 6'd33;
      "<": k = 6'd38;
      ">": k = 6'd39;
      "=": k = 6'd40;
      ";": k = 6'd41;
      "{": k = 6'd42;
      "}": k = 6'd43;
      ":": k = 6'd44;
      ",": k = 6'd45;
      ".": k = 6'd46;
      "?": k = 6'd47;
      "!": k = 6'd48;
      "+": k = 6'd49;
      "-": k = 6'd50;
      "*": k = 6'd51;
      "/": k = 6'd52;
      "(": k = 6'd53;
      ")": k = 6'd54;
      "%": k = 6'd55;
      default: k = CODE_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_code(logic [7:0] a, logic [7:0] b);
    logic [5:0] k;
    case ({a, b})
      "+=": k = 6'd21;
      "-=": k = 6'd22;
      "*=": k = 6'd23;
      "/=": k = 6'd24;
      "%=": k = 6'd25;
      "&&": k = 6'd26;
      "||": k = 6'd27;
      "++": k = 6'd28;
      "--": k = 6'd29;
      "->": k = 6'd30;
      "==": k = 6'd34;
      "!=": k = 6'd35;
      "<=": k = 6'd36;
      ">=": k = 6'd37;
      default: k = CODE_NONE;
    endcase
    return k;
  endfunction

  // prefix is shifted in, so a short word sits right justified like a literal
  function automatic logic [5:0] kw_code(logic [63:0] w);
    logic [5:0] k;
    case (w)
      64'("continue"): k = 6'd0;
      64'("typedef"):  k = 6'd1;
      64'("extern"):   k = 6'd2;
      64'("sizeof"):   k = 6'd3;
      64'("default"):  k = 6'd4;
      64'("break"):    k = 6'd5;
      64'("int"):      k = 6'd6;
      64'("char"):     k = 6'd7;
      64'("struct"):   k = 6'd8;
      64'("enum"):     k = 6'd9;
      64'("void"):     k = 6'd10;
      64'("return"):   k = 6'd11;
      64'("if"):       k = 6'd12;
      64'("else"):     k = 6'd13;
      64'("switch"):   k = 6'd14;
      64'("case"):     k = 6'd15;
      64'("for"):      k = 6'd16;
      64'("while"):    k = 6'd17;
      default:         k = CODE_NONE;
    endcase
    return k;
  endfunction

endpackage

### rtl/core/c_subset_lexer_core.sv
// c subset lexer: source text in, one byte per item, tokens out.
// input queue side: drive data_i with a byte and its end-of-text mark and
// raise push_i; the item is taken on a clock edge where full_o is low.
// output side: while empty_o is low the oldest token is on data_o and is
// taken on an edge with pop_i high.
// the front lexer handles one byte per cycle while full_o is low, turning
// it into zero to four tokens written as one bundle into a four-entry queue;
// the back end hands out the head bundle one token per cycle with pop_i high.
// a token completed by a byte enters the queue when that byte is taken and
// shows on data_o once the tokens ahead of it are taken. input runs at one
// byte per cycle while tokens are drained at least as fast as they appear.
// full_o rises when four bundles wait, so a stalled receiver stops input
// after at most four bytes that produce tokens.
// reset clears the lexer state, the byte position and the queue; the block
// is ready for text on the first cycle after reset.
module c_subset_lexer_core #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  clx_pkg::in_item_t data_i,
  output logic              empty_o,
  input  logic              pop_i,
  output clx_pkg::token_t   data_o
);

  logic             f_push;
  clx_pkg::bundle_t f_bundle;
  logic             q_pop, q_empty;
  clx_pkg::bundle_t q_data;

  clx_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (push_i && !full_o),
    .item_i   (data_i),
    .push_o   (f_push),
    .bundle_o (f_bundle)
  );

  clx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_bundle),
    .full_o  (full_o),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  clx_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .empty_o   (empty_o),
    .pop_i     (pop_i),
    .data_o    (data_o)
  );

  last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (data_o.last_token == (data_o.token_kind == clx_pkg::KIND_END)))
    else $error("last flag off the end token");

  err_is_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |->
      ((data_o.error_code != clx_pkg::ERR_NONE) ==
       (data_o.token_kind == clx_pkg::KIND_ERROR)))
    else $error("error code on non-error token");

  end_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && data_o.token_kind == clx_pkg::KIND_END) |-> (data_o.token_length == '0))
    else $error("end token with length");

endmodule

### rtl/core/clx_front.sv
module clx_front #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  clx_pkg::in_item_t item_i,
  output logic              push_o,
  output clx_pkg::bundle_t  bundle_o
);

  localparam int unsigned PB = POSITION_BITS;

  clx_pkg::lex_mode_e mode_q, mode_d;
  logic [15:0]   held_q, held_d;
  logic [1:0]    hcnt_q, hcnt_d;
  logic [PB-1:0] pos_q, pos_d;
  logic [PB-1:0] org_q, org_d;
  logic [15:0]   run_q, run_d;
  logic [63:0]   pref_q, pref_d;
  logic [30:0]   acc_q, acc_d;
  logic          flag_q, flag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= clx_pkg::MODE_IDLE;
      held_q <= '0;
      hcnt_q <= '0;
      pos_q  <= '0;
      org_q  <= '0;
      run_q  <= '0;
      pref_q <= '0;
      acc_q  <= '0;
      flag_q <= 1'b0;
    end else if (valid_i) begin
      mode_q <= mode_d;
      held_q <= held_d;
      hcnt_q <= hcnt_d;
      pos_q  <= pos_d;
      org_q  <= org_d;
      run_q  <= run_d;
      pref_q <= pref_d;
      acc_q  <= acc_d;
      flag_q <= flag_d;
    end
  end

  function automatic logic [15:0] lo16(logic [PB-1:0] p);
    logic [PB+15:0] e;
    e = {16'd0, p};
    return e[15:0];
  endfunction

  function automatic logic [15:0] sat_inc(logic [15:0] r);
    return (r == 16'hFFFF) ? r : r + 16'd1;
  endfunction

  logic [7:0]        c;
  logic              cont;
  logic [2:0]        n;
  clx_pkg::token_t [clx_pkg::MaxTokens-1:0] tk;
  logic [34:0]       prod;
  logic [5:0]        k;
  logic [30:0]       cv;

  always_comb begin
    c      = item_i.text_byte;
    cont   = 1'b0;
    n      = 3'd0;
    tk     = '0;
    prod   = '0;
    k      = clx_pkg::CODE_NONE;
    cv     = '0;
    mode_d = mode_q;
    held_d = held_q;
    hcnt_d = hcnt_q;
    org_d  = org_q;
    run_d  = run_q;
    pref_d = pref_q;
    acc_d  = acc_q;
    flag_d = flag_q;
    pos_d  = pos_q + 1'b1;

    unique case (mode_q)
      clx_pkg::MODE_IDLE: cont = 1'b1;
      clx_pkg::MODE_WORD: begin
        if (clx_pkg::is_letter(c) || clx_pkg::is_digit(c)) begin
          if (run_q < 16'(clx_pkg::KwMaxChars)) pref_d = {pref_q[55:0], c};
          run_d = sat_inc(run_q);
        end else begin
          k = (run_q <= 16'(clx_pkg::KwMaxChars)) ? clx_pkg::kw_code(pref_q)
                                                  : clx_pkg::CODE_NONE;
          tk[n[1:0]] = (k != clx_pkg::CODE_NONE)
            ? clx_pkg::mk_tok(clx_pkg::KIND_RESERVED, k, lo16(org_q), run_q, '0,
                              clx_pkg::ERR_NONE, 1'b0)
            : clx_pkg::mk_tok(clx_pkg::KIND_IDENT, '0, lo16(org_q), run_q, '0,
                              clx_pkg::ERR_NONE, 1'b0);
          n = n + 3'd1;
          mode_d = clx_pkg::MODE_IDLE;
          cont = 1'b1;
        end
      end
      clx_pkg::MODE_NUM: begin
        if (clx_pkg::is_digit(c)) begin
          prod  = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + 35'(c - "0");
          acc_d = (prod > 35'(clx_pkg::ValueMax)) ? clx_pkg::ValueMax : prod[30:0];
          run_d = sat_inc(run_q);
        end else begin
          tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_NUMBER, '0, lo16(org_q), run_q,
                                       acc_q, clx_pkg::ERR_NONE, 1'b0);
          n = n + 3'd1;
          mode_d = clx_pkg::MODE_IDLE;
          cont = 1'b1;
        end
      end
      clx_pkg::MODE_STR: begin
        run_d = sat_inc(run_q);
        if (c == "\"") begin
          tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_STRING, '0, lo16(org_q), run_d,
                                       '0, clx_pkg::ERR_NONE, 1'b0);
          n = n + 3'd1;
          mode_d = clx_pkg::MODE_IDLE;
        end
      end
      clx_pkg::MODE_CHR_FIRST: begin
        held_d = {8'd0, c};
        run_d  = sat_inc(run_q);
        flag_d = (c == 8'd92);
        mode_d = clx_pkg::MODE_CHR_BODY;
      end
      clx_pkg::MODE_CHR_BODY: begin
        run_d = sat_inc(run_q);
        if (run_d == 16'd3) held_d = {c, held_q[7:0]};
        if (flag_q) begin
          flag_d = 1'b0;
        end else if (c == 8'd39) begin
          mode_d = clx_pkg::MODE_IDLE;
          if (run_d == 16'd3) begin
            tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_CHAR, '0, lo16(org_q), 16'd3,
                                         {23'd0, held_d[7:0]}, clx_pkg::ERR_NONE, 1'b0);
          end else if (run_d == 16'd4) begin
            if (held_d[7:0] == 8'd92) begin
              case (held_d[15:8])
                "t": cv = 31'd9;
                "n": cv = 31'd10;
                "r": cv = 31'd13;
                default: cv = '0;
              endcase
            end
            tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_CHAR, '0, lo16(org_q), 16'd4,
                                         cv, clx_pkg::ERR_NONE, 1'b0);
          end else begin
            tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_ERROR, '0, lo16(org_q), run_d,
                                         '0, clx_pkg::ERR_BAD_CHAR, 1'b0);
            mode_d = clx_pkg::MODE_DISCARD;
          end
          n = n + 3'd1;
        end else if (c == 8'd92) begin
          flag_d = 1'b1;
        end
      end
      clx_pkg::MODE_SLASH: begin
        if (c == "/") begin
          run_d  = sat_inc(run_q);
          mode_d = clx_pkg::MODE_LINECOM;
        end else if (c == "*") begin
          run_d  = sat_inc(run_q);
          flag_d = 1'b0;
          mode_d = clx_pkg::MODE_BLOCKCOM;
        end else if (c == "=") begin
          tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_RESERVED, clx_pkg::CODE_SLASH_EQ,
                                       lo16(org_q), 16'd2, '0, clx_pkg::ERR_NONE, 1'b0);
          n = n + 3'd1;
          mode_d = clx_pkg::MODE_IDLE;
        end else begin
          tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_RESERVED, clx_pkg::CODE_SLASH,
                                       lo16(org_q), 16'd1, '0, clx_pkg::ERR_NONE, 1'b0);
          n = n + 3'd1;
          mode_d = clx_pkg::MODE_IDLE;
          cont = 1'b1;
        end
      end
      clx_pkg::MODE_LINECOM: begin
        run_d = sat_inc(run_q);
        if (c == 8'd10) mode_d = clx_pkg::MODE_IDLE;
      end
      clx_pkg::MODE_BLOCKCOM: begin
        run_d = sat_inc(run_q);
        if (flag_q && c == "/") mode_d = clx_pkg::MODE_IDLE;
        else flag_d = (c == "*");
      end
      clx_pkg::MODE_PUNCT: begin
        k = clx_pkg::pair_code(held_q[7:0], c);
        mode_d = clx_pkg::MODE_IDLE;
        if (k != clx_pkg::CODE_NONE) begin
          tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_RESERVED, k, lo16(org_q), 16'd2,
                                       '0, clx_pkg::ERR_NONE, 1'b0);
        end else begin
          tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_RESERVED,
                                       clx_pkg::single_code(held_q[7:0]), lo16(org_q),
                                       16'd1, '0, clx_pkg::ERR_NONE, 1'b0);
          cont = 1'b1;
        end
        n = n + 3'd1;
      end
      clx_pkg::MODE_DOT: begin
        if (c == ".") begin
          if (hcnt_q == 2'd2) begin
            tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_RESERVED, clx_pkg::CODE_ELLIPSIS,
                                         lo16(org_q), 16'd3, '0, clx_pkg::ERR_NONE, 1'b0);
            n = n + 3'd1;
            mode_d = clx_pkg::MODE_IDLE;
          end else begin
            hcnt_d = 2'd2;
          end
        end else begin
          tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_RESERVED, clx_pkg::CODE_DOT,
                                       lo16(org_q), 16'd1, '0, clx_pkg::ERR_NONE, 1'b0);
          n = n + 3'd1;
          if (hcnt_q == 2'd2) begin
            tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_RESERVED, clx_pkg::CODE_DOT,
                                         lo16(org_q + 1'b1), 16'd1, '0,
                                         clx_pkg::ERR_NONE, 1'b0);
            n = n + 3'd1;
          end
          mode_d = clx_pkg::MODE_IDLE;
          cont = 1'b1;
        end
      end
      clx_pkg::MODE_DISCARD: ;
      default: ;
    endcase

    // new token starts on this byte
    if (cont && !clx_pkg::is_space(c)) begin
      org_d = pos_q;
      run_d = 16'd1;
      if (c == "/") begin
        mode_d = clx_pkg::MODE_SLASH;
      end else if (c == "\"") begin
        mode_d = clx_pkg::MODE_STR;
      end else if (c == 8'd39) begin
        mode_d = clx_pkg::MODE_CHR_FIRST;
      end else if (clx_pkg::is_letter(c)) begin
        pref_d = {56'd0, c};
        mode_d = clx_pkg::MODE_WORD;
      end else if (clx_pkg::is_digit(c)) begin
        acc_d  = 31'(c - "0");
        mode_d = clx_pkg::MODE_NUM;
      end else if (c == ".") begin
        hcnt_d = 2'd1;
        mode_d = clx_pkg::MODE_DOT;
      end else if (clx_pkg::has_pair(c)) begin
        held_d = {8'd0, c};
        mode_d = clx_pkg::MODE_PUNCT;
      end else if (clx_pkg::single_code(c) != clx_pkg::CODE_NONE) begin
        tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_RESERVED, clx_pkg::single_code(c),
                                     lo16(pos_q), 16'd1, '0, clx_pkg::ERR_NONE, 1'b0);
        n = n + 3'd1;
      end else begin
        tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_ERROR, '0, lo16(pos_q), 16'd1, '0,
                                     clx_pkg::ERR_UNKNOWN, 1'b0);
        n = n + 3'd1;
        mode_d = clx_pkg::MODE_DISCARD;
      end
    end

    // end of text: flush, end token, back to reset state
    if (item_i.end_of_text) begin
      case (mode_d)
        clx_pkg::MODE_WORD: begin
          k = (run_d <= 16'(clx_pkg::KwMaxChars)) ? clx_pkg::kw_code(pref_d)
                                                  : clx_pkg::CODE_NONE;
          tk[n[1:0]] = (k != clx_pkg::CODE_NONE)
            ? clx_pkg::mk_tok(clx_pkg::KIND_RESERVED, k, lo16(org_d), run_d, '0,
                              clx_pkg::ERR_NONE, 1'b0)
            : clx_pkg::mk_tok(clx_pkg::KIND_IDENT, '0, lo16(org_d), run_d, '0,
                              clx_pkg::ERR_NONE, 1'b0);
          n = n + 3'd1;
        end
        clx_pkg::MODE_NUM: begin
          tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_NUMBER, '0, lo16(org_d), run_d,
                                       acc_d, clx_pkg::ERR_NONE, 1'b0);
          n = n + 3'd1;
        end
        clx_pkg::MODE_SLASH: begin
          tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_RESERVED, clx_pkg::CODE_SLASH,
                                       lo16(org_d), 16'd1, '0, clx_pkg::ERR_NONE, 1'b0);
          n = n + 3'd1;
        end
        clx_pkg::MODE_PUNCT: begin
          tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_RESERVED,
                                       clx_pkg::single_code(held_d[7:0]), lo16(org_d),
                                       16'd1, '0, clx_pkg::ERR_NONE, 1'b0);
          n = n + 3'd1;
        end
        clx_pkg::MODE_DOT: begin
          tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_RESERVED, clx_pkg::CODE_DOT,
                                       lo16(org_d), 16'd1, '0, clx_pkg::ERR_NONE, 1'b0);
          n = n + 3'd1;
          if (hcnt_d == 2'd2) begin
            tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_RESERVED, clx_pkg::CODE_DOT,
                                         lo16(org_d + 1'b1), 16'd1, '0,
                                         clx_pkg::ERR_NONE, 1'b0);
            n = n + 3'd1;
          end
        end
        clx_pkg::MODE_STR, clx_pkg::MODE_CHR_FIRST, clx_pkg::MODE_CHR_BODY: begin
          tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_ERROR, '0, lo16(org_d), run_d, '0,
                                       clx_pkg::ERR_OPEN_LIT, 1'b0);
          n = n + 3'd1;
        end
        clx_pkg::MODE_LINECOM, clx_pkg::MODE_BLOCKCOM: begin
          tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_ERROR, '0, lo16(org_d), run_d, '0,
                                       clx_pkg::ERR_OPEN_COM, 1'b0);
          n = n + 3'd1;
        end
        default: ;
      endcase
      tk[n[1:0]] = clx_pkg::mk_tok(clx_pkg::KIND_END, '0, lo16(pos_d), 16'd0, '0,
                                   clx_pkg::ERR_NONE, 1'b1);
      n = n + 3'd1;
      mode_d = clx_pkg::MODE_IDLE;
      held_d = '0;
      hcnt_d = '0;
      pos_d  = '0;
      org_d  = '0;
      run_d  = '0;
      pref_d = '0;
      acc_d  = '0;
      flag_d = 1'b0;
    end
  end

  assign push_o        = valid_i && (n != 3'd0);
  assign bundle_o.toks = tk;
  assign bundle_o.cnt  = n;

endmodule

### rtl/core/clx_queue.sv
module clx_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  clx_pkg::bundle_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output clx_pkg::bundle_t data_o
);

  localparam int unsigned Depth = clx_pkg::QueueDepth;
  localparam int unsigned AW    = $clog2(Depth);

  clx_pkg::bundle_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + 1'b1;
      if (do_pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

### rtl/core/clx_back.sv
module clx_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  clx_pkg::bundle_t q_data_i,
  output logic             q_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output clx_pkg::token_t  data_o
);

  logic [1:0] idx_q;
  logic       last;

  assign empty_o = q_empty_i;
  assign data_o  = q_data_i.toks[idx_q];
  assign last    = ({1'b0, idx_q} + 3'd1) == q_data_i.cnt;
  assign q_pop_o = pop_i && !q_empty_i && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (pop_i && !q_empty_i) begin
      idx_q <= last ? 2'd0 : idx_q + 2'd1;
    end
  end

  idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty_i |-> ({1'b0, idx_q} < q_data_i.cnt))
    else $error("token index beyond bundle");

  idx_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (idx_q == 2'd0))
    else $error("index not cleared after bundle");

  idx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_i |=> $stable(idx_q))
    else $error("index moved without pop");

endmodule
